// ----- design/mlc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared constants and operation codes of the method lookup cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlc_pkg;

    // default geometry
    localparam int DEF_ENTRIES   = 256;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_PTR_WIDTH = 32;

    // fixed port widths
    localparam int FIELD_WIDTH = 32;
    localparam int KIND_WIDTH  = 2;

    // class, selector, code per way
    localparam int ENTRY_FIELDS = 3;

    typedef logic [KIND_WIDTH-1:0] kind_t;

    localparam kind_t KIND_LOOKUP    = kind_t'(0);
    localparam kind_t KIND_INSERT    = kind_t'(1);
    localparam kind_t KIND_INVAL_SEL = kind_t'(2);
    localparam kind_t KIND_FLUSH     = kind_t'(3);

endpackage

// ----- design/mlc_store.sv -----
// ----------------------------------------------------------------------------
// mlc_store
// Set-wide storage: one data row and one valid row per set, registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlc_store
    import mlc_pkg::*;
#(
    parameter int SETS      = DEF_ENTRIES / DEF_WAYS,
    parameter int WAYS      = DEF_WAYS,
    parameter int PTR_WIDTH = DEF_PTR_WIDTH
)
(
    input  logic                                      clk,
    input  logic                                      rd_en,
    input  logic [$clog2(SETS)-1:0]                   rd_addr,
    output logic [WAYS*ENTRY_FIELDS*PTR_WIDTH-1:0]    rd_data,
    output logic [WAYS-1:0]                           rd_valid,
    input  logic                                      wr_data_en,
    input  logic                                      wr_valid_en,
    input  logic [$clog2(SETS)-1:0]                   wr_addr,
    input  logic [WAYS*ENTRY_FIELDS*PTR_WIDTH-1:0]    wr_data,
    input  logic [WAYS-1:0]                           wr_valid
);

    localparam int ROW_W = WAYS * ENTRY_FIELDS * PTR_WIDTH;

    logic [ROW_W-1:0] data_mem  [SETS];
    logic [WAYS-1:0]  valid_mem [SETS];

    always_ff @(posedge clk)
    begin
        if (wr_data_en)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid_en)
        begin
            valid_mem[wr_addr] <= wr_valid;
        end
        if (rd_en)
        begin
            rd_valid <= valid_mem[rd_addr];
        end
    end

endmodule

// ----- design/mlc_match.sv -----
// ----------------------------------------------------------------------------
// mlc_match
// Way compare and row update for one set: lookup hit, insert, selector kill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlc_match
    import mlc_pkg::*;
#(
    parameter int WAYS      = DEF_WAYS,
    parameter int PTR_WIDTH = DEF_PTR_WIDTH
)
(
    input  kind_t                                     op,
    input  logic [PTR_WIDTH-1:0]                      cls,
    input  logic [PTR_WIDTH-1:0]                      sel,
    input  logic [PTR_WIDTH-1:0]                      code,
    input  logic [WAYS*ENTRY_FIELDS*PTR_WIDTH-1:0]    row_data,
    input  logic [WAYS-1:0]                           row_valid,
    output logic                                      hit,
    output logic [PTR_WIDTH-1:0]                      hit_code,
    output logic [WAYS*ENTRY_FIELDS*PTR_WIDTH-1:0]    wr_data,
    output logic [WAYS-1:0]                           wr_valid
);

    localparam int ENT_W = ENTRY_FIELDS * PTR_WIDTH;

    logic [PTR_WIDTH-1:0] e_code [WAYS];
    logic [PTR_WIDTH-1:0] e_sel  [WAYS];
    logic [PTR_WIDTH-1:0] e_cls  [WAYS];
    logic [WAYS-1:0]      key_eq;
    logic [WAYS-1:0]      kill;
    logic [WAYS-1:0]      free_sel;
    logic                 free_found;
    logic [ENT_W-1:0]     new_entry;

    // way layout: {class, selector, code}
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            e_code[w] = row_data[w*ENT_W +: PTR_WIDTH];
            e_sel[w]  = row_data[w*ENT_W + PTR_WIDTH +: PTR_WIDTH];
            e_cls[w]  = row_data[w*ENT_W + 2*PTR_WIDTH +: PTR_WIDTH];
            key_eq[w] = row_valid[w] && (e_cls[w] == cls) && (e_sel[w] == sel);
            kill[w]   = row_valid[w] && (e_sel[w] == sel);
        end
    end

    // lowest way wins: scan downward, last assignment sticks
    always_comb
    begin
        hit        = 1'b0;
        hit_code   = '0;
        free_found = 1'b0;
        free_sel   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (key_eq[w])
            begin
                hit      = 1'b1;
                hit_code = e_code[w];
            end
            if (!row_valid[w])
            begin
                free_found = 1'b1;
                free_sel   = WAYS'(1) << w;
            end
        end
    end

    always_comb
    begin
        new_entry = {cls, sel, code};
        wr_data   = row_data;
        wr_valid  = row_valid;
        case (op)
            KIND_INSERT:
            begin
                if (free_found)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (free_sel[w])
                        begin
                            wr_data[w*ENT_W +: ENT_W] = new_entry;
                        end
                    end
                    wr_valid = row_valid | free_sel;
                end
                else
                begin
                    // full set: take way 0, drop the rest
                    wr_data[0 +: ENT_W] = new_entry;
                    wr_valid            = WAYS'(1);
                end
            end
            KIND_INVAL_SEL:
            begin
                wr_valid = row_valid & ~kill;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/method_lookup_cache_unit.sv -----
// Lookup and insert: a result strobe follows the start transfer; busy holds until the set is done, so a new one waits.
// Invalidate selector: walks every set, then gives the result strobe.
// Flush: clears one set per cycle, then gives the result strobe.
// Pace is set by the set memory's registered read: read one cycle, modify and write in the cycle after.
// Reset: asynchronous, active low; a clearing pass over every set follows with busy high.
// The receiver cannot stall: each result is on the ports for exactly the done cycle.
// ----------------------------------------------------------------------------
// method_lookup_cache_unit
// Set-associative dispatch cache keyed by (class, selector), holding a code
// pointer per entry. Set rows live in a synchronous memory; a sequencer reads
// one set per lookup, does read-modify-write of one set per insert, and walks all sets for the
// invalidate and flush operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module method_lookup_cache_unit
    import mlc_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,   // power of two
    parameter int WAYS      = DEF_WAYS,      // power of two
    parameter int PTR_WIDTH = DEF_PTR_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  kind_t                  kind,
    input  logic [FIELD_WIDTH-1:0] class_ptr,
    input  logic [FIELD_WIDTH-1:0] selector_ptr,
    input  logic [FIELD_WIDTH-1:0] code_ptr,
    output logic                   busy,
    output logic                   done,
    output logic                   hit,
    output logic [FIELD_WIDTH-1:0] found_code
);

    localparam int SETS     = ENTRIES / WAYS;
    localparam int WAY_BITS = $clog2(WAYS);
    localparam int SET_BITS = $clog2(SETS);
    localparam int ROW_W    = WAYS * ENTRY_FIELDS * PTR_WIDTH;

    localparam logic [SET_BITS-1:0] ROW_LAST = SET_BITS'(SETS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;   // set row read back, update it
    localparam logic [1:0] ST_SWEEP = 2'd2;   // selector invalidate walk
    localparam logic [1:0] ST_WIPE  = 2'd3;   // flush or post-reset clear

    logic [1:0]          state_reg, state_next;
    logic [SET_BITS-1:0] row_reg, row_next;
    logic                report_reg, report_next;   // wipe ends in a result
    logic                done_reg, done_next;
    logic                hit_reg, hit_next;
    logic [FIELD_WIDTH-1:0] found_code_reg, found_code_next;

    // held operation (payload, no reset)
    kind_t                op_reg;
    logic [PTR_WIDTH-1:0] cls_reg;
    logic [PTR_WIDTH-1:0] sel_reg;
    logic [PTR_WIDTH-1:0] code_reg;
    logic [SET_BITS-1:0]  set_reg;

    logic                 accept;
    logic [PTR_WIDTH-1:0] cls_in;
    logic [PTR_WIDTH-1:0] sel_in;
    logic [PTR_WIDTH-1:0] mix_in;
    logic [SET_BITS-1:0]  set_in;

    // store and match wiring
    logic                rd_en;
    logic [SET_BITS-1:0] rd_addr;
    logic [ROW_W-1:0]    rd_data;
    logic [WAYS-1:0]     rd_valid;
    logic                wr_data_en;
    logic                wr_valid_en;
    logic [SET_BITS-1:0] wr_addr;
    logic [ROW_W-1:0]    upd_data;
    logic [WAYS-1:0]     upd_valid;
    logic [WAYS-1:0]     wr_valid;
    logic                m_hit;
    logic [PTR_WIDTH-1:0] m_code;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // keys in PTR_WIDTH bits; set from the bits just above the way bits
    assign cls_in = PTR_WIDTH'(class_ptr);
    assign sel_in = PTR_WIDTH'(selector_ptr);
    assign mix_in = cls_in ^ sel_in;
    assign set_in = mix_in[WAY_BITS +: SET_BITS];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= kind;
            cls_reg  <= cls_in;
            sel_reg  <= sel_in;
            code_reg <= PTR_WIDTH'(code_ptr);
            set_reg  <= set_in;
        end
    end

    // read port: the set on a lookup/insert transfer, else the next row of the walk
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = set_in;
        if (accept && (kind == KIND_LOOKUP || kind == KIND_INSERT))
        begin
            rd_en = 1'b1;
        end
        else if (accept && kind == KIND_INVAL_SEL)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (state_reg == ST_SWEEP && row_reg != ROW_LAST)
        begin
            rd_en   = 1'b1;
            rd_addr = row_reg + SET_BITS'(1);
        end
    end

    // write port: the evaluated set or the walk row; a wipe writes zero valids.
    // Walk reads row+1 while writing row, so reads and writes never meet.
    always_comb
    begin
        wr_data_en  = (state_reg == ST_EVAL) && (op_reg == KIND_INSERT);
        wr_valid_en = wr_data_en || (state_reg == ST_SWEEP) || (state_reg == ST_WIPE);
        wr_addr     = (state_reg == ST_EVAL) ? set_reg : row_reg;
        wr_valid    = (state_reg == ST_WIPE) ? '0 : upd_valid;
    end

    mlc_store #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .PTR_WIDTH (PTR_WIDTH)
    ) u_store (
        .clk         (clk),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .rd_valid    (rd_valid),
        .wr_data_en  (wr_data_en),
        .wr_valid_en (wr_valid_en),
        .wr_addr     (wr_addr),
        .wr_data     (upd_data),
        .wr_valid    (wr_valid)
    );

    mlc_match #(
        .WAYS      (WAYS),
        .PTR_WIDTH (PTR_WIDTH)
    ) u_match (
        .op        (op_reg),
        .cls       (cls_reg),
        .sel       (sel_reg),
        .code      (code_reg),
        .row_data  (rd_data),
        .row_valid (rd_valid),
        .hit       (m_hit),
        .hit_code  (m_code),
        .wr_data   (upd_data),
        .wr_valid  (upd_valid)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        report_next     = report_reg;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        found_code_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_LOOKUP, KIND_INSERT:
                        begin
                            state_next = ST_EVAL;
                        end
                        KIND_INVAL_SEL:
                        begin
                            state_next = ST_SWEEP;
                            row_next   = '0;
                        end
                        default:
                        begin
                            state_next  = ST_WIPE;
                            row_next    = '0;
                            report_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == KIND_LOOKUP && m_hit)
                begin
                    hit_next        = 1'b1;
                    found_code_next = FIELD_WIDTH'(m_code);
                end
            end
            ST_SWEEP:
            begin
                row_next = row_reg + SET_BITS'(1);
                if (row_reg == ROW_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE:
            begin
                row_next = row_reg + SET_BITS'(1);
                if (row_reg == ROW_LAST)
                begin
                    // post-reset clear gives no result
                    done_next   = report_reg;
                    report_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WIPE;
            row_reg    <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        found_code_reg <= found_code_next;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign found_code = found_code_reg;

`ifndef SYNTHESIS
    // a result always leaves the block ready for the next transfer
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    // every transfer starts some work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("transfer did not start an operation");

    // only lookups report a hit
    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (op_reg == KIND_LOOKUP))
        else $error("hit reported for a non-lookup operation");

    // set evaluation follows directly on its read
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> $past(rd_en && accept))
        else $error("set evaluated without a preceding read");
`endif

endmodule
